@@ src/binary_to_decimal_ascii_macros.svh @@
// Assertion helpers shared by the RTL; both sample on clk_i and are
// quiet while rst_ni is low.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define B2DA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define B2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da: next-cycle check failed");

`endif

@@ src/b2da_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  localparam int unsigned InValueWidth = 64;
  localparam int unsigned CharWidth    = 6;

  localparam logic [CharWidth-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CharWidth-1:0] ASCII_MINUS = 6'd45;

  // Smallest BCD digit that gets +3 before a shift.
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;

  typedef struct packed {
    logic [InValueWidth-1:0] value;
    logic                    signed_mode;
  } in_t;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } out_t;

  // Per-cycle command to every digit cell of the row.
  typedef struct packed {
    logic clr;     // clear the digit
    logic dabble;  // add-3 and shift one binary bit in
    logic dshift;  // take the digit of the lower neighbour
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/b2da_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b2da_cell (
  input  wire                     clk_i,
  input  b2da_pkg::cell_ctrl_t    ctrl_i,
  input  wire                     bit_i,
  output logic                    bit_o,
  input  wire  [3:0]              digit_i,
  output logic [3:0]              digit_o
);
  import b2da_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // Correct the digit before it doubles, so it never passes nine.
  assign adj   = (digit_q >= DABBLE_MIN) ? (digit_q + DABBLE_ADD) : digit_q;
  assign bit_o = adj[3];

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.dshift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

@@ src/b2da_cell_row.sv @@
`timescale 1ns / 1ps
`default_nettype none

module b2da_cell_row #(
  parameter int unsigned NumDigits = 20
) (
  input  wire                     clk_i,
  input  b2da_pkg::cell_ctrl_t    ctrl_i,
  input  wire                     bit_i,
  output logic                    carry_o,
  output logic [3:0]              top_digit_o
);
  import b2da_pkg::*;

  logic [NumDigits:0]   carry;
  logic [3:0]           digit [NumDigits+1];

  assign carry[0] = bit_i;
  assign digit[0] = 4'd0;

  // Cell 0 is the units digit; binary bits climb upwards, digits climb
  // upwards too when the row is read out most significant first.
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    b2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .bit_i   (carry[i]),
      .bit_o   (carry[i+1]),
      .digit_i (digit[i]),
      .digit_o (digit[i+1])
    );
  end

  assign carry_o     = carry[NumDigits];
  assign top_digit_o = digit[NumDigits];

endmodule

`default_nettype wire

@@ src/binary_to_decimal_ascii.sv @@
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_stall_o | b2da_pkg::in_t  (value, signed_mode)
// output  | out       | out_valid_o/out_stall_i | b2da_pkg::out_t (character, last)
//
// Each number: a transfer, VALUE_WIDTH conversion steps (one bit a cycle
// through the BCD cell row), a minus sign for a negative value, then the NDIG
// digits of the row (20 at 64 bits), one per cycle while the output does not stall.
// The input stalls until the row is read out; the output register may still hold
// the last character. Reset clears the sequencer and the output valid only.
// A stalled output holds its transfer and delays the next character, while
// leading zeros are still dropped.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  b2da_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output b2da_pkg::out_t   out_data_o
);
  import b2da_pkg::*;

  `include "binary_to_decimal_ascii_macros.svh"

  // Digits of the largest unsigned value: floor(W * log10(2)) + 1.
  localparam int unsigned NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned BCW  = $clog2(VALUE_WIDTH);
  localparam int unsigned DCW  = $clog2(NDIG + 1);

  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] sh_q, sh_d;
  logic                   minus_q, minus_d;
  logic [BCW-1:0]         bit_cnt_q, bit_cnt_d;
  logic [DCW-1:0]         dig_cnt_q, dig_cnt_d;
  logic                   started_q, started_d;
  out_t                   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  cell_ctrl_t             ctrl;
  logic                   carry_out;
  logic [3:0]             top_digit;

  logic                   in_accept;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] v;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   last_pos;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new character when empty or draining.
  assign out_free   = !out_valid_q || !out_stall_i;

  // Only the low VALUE_WIDTH bits count. The most negative value negates to
  // itself, which is already its magnitude; it gets no minus sign.
  assign v   = in_data_i.value[VALUE_WIDTH-1:0];
  assign neg = in_data_i.signed_mode && v[VALUE_WIDTH-1];
  assign mag = neg ? (~v + VALUE_WIDTH'(1)) : v;

  assign last_pos = (dig_cnt_q == DCW'(1));

  b2da_cell_row #(
    .NumDigits (NDIG)
  ) u_row (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .bit_i       (sh_q[VALUE_WIDTH-1]),
    .carry_o     (carry_out),
    .top_digit_o (top_digit)
  );

  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    minus_d     = minus_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    started_d   = started_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl        = '0;

    unique case (state_q)
      ST_IDLE: begin
        // Take a number, clear the row and load the magnitude.
        if (in_accept) begin
          ctrl.clr  = 1'b1;
          sh_d      = mag;
          minus_d   = neg && (v != SIGN_BIT);
          bit_cnt_d = BCW'(VALUE_WIDTH - 1);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // Shift one magnitude bit, MSB first, into the units cell.
        ctrl.dabble = 1'b1;
        sh_d        = {sh_q[VALUE_WIDTH-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DCW'(NDIG);
          started_d = 1'b0;
          state_d   = minus_q ? ST_SIGN : ST_EMIT;
        end else begin
          bit_cnt_d = bit_cnt_q - BCW'(1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_d.character = ASCII_MINUS;
          out_d.last      = 1'b0;
          out_valid_d     = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_q && (top_digit == 4'd0) && !last_pos) begin
          // Drop a leading zero; the units digit is always sent.
          ctrl.dshift = 1'b1;
          dig_cnt_d   = dig_cnt_q - DCW'(1);
        end else if (out_free) begin
          out_d.character = ASCII_ZERO + {2'b00, top_digit};
          out_d.last      = last_pos;
          out_valid_d     = 1'b1;
          ctrl.dshift     = 1'b1;
          started_d       = 1'b1;
          dig_cnt_d       = dig_cnt_q - DCW'(1);
          if (last_pos) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data path: no reset needed.
  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    minus_q <= minus_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The row is sized for the widest value, so no bit may fall off its top.
  `B2DA_ASSERT_SAME(a_row_no_overflow, state_q == ST_CONV, !carry_out)
  // An accepted number always starts conversion next cycle.
  `B2DA_ASSERT_NEXT(a_accept_starts_conv, in_accept, state_q == ST_CONV)
  // Read-out never runs with an exhausted digit count.
  `B2DA_ASSERT_SAME(a_emit_count_live, state_q == ST_EMIT, dig_cnt_q != '0)

endmodule

`default_nettype wire

@@ bench/tb_binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam logic [63:0] SIGN_ONLY     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DEC_BASE      = 64'd10;
  localparam int          MAX_GAP       = 5;
  localparam int          SETTLE_CYCLES = 150;
  localparam int          PHASE_ITEMS   = 50;
  localparam int          PHASES        = 5;
  localparam int          TIMEOUT_NS    = 1_000_000;

  // Expected characters of every number in flight, oldest first.
  class decimal_text_scoreboard;
    out_t expected_chars[$];
    int   mismatches;
    int   numbers_seen;
    int   chars_checked;

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out the decimal text of one accepted number and queue it.
    function void note_number(in_t item);
      logic [63:0] magnitude;
      logic [3:0]  digits [20];
      int          ndig;
      bit          minus;
      out_t        ch;
      magnitude = item.value;
      minus     = 1'b0;
      ndig      = 0;
      if (item.signed_mode && item.value[63]) begin
        // The most negative value keeps its magnitude and loses its sign.
        if (item.value != SIGN_ONLY) begin
          magnitude = ~item.value + 64'd1;
          minus     = 1'b1;
        end
      end
      do begin
        digits[ndig] = 4'(magnitude % DEC_BASE);
        magnitude    = magnitude / DEC_BASE;
        ndig++;
      end while (magnitude != 0);
      if (minus) begin
        ch.character = ASCII_MINUS;
        ch.last      = 1'b0;
        expected_chars.push_back(ch);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
        ch.character = ASCII_ZERO + 6'(digits[k]);
        ch.last      = (k == 0);
        expected_chars.push_back(ch);
      end
      numbers_seen++;
    endfunction

    task check_char(out_t got);
      out_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report($sformatf("character %0d (last %0b) with nothing outstanding",
                         got.character, got.last));
      end else begin
        want = expected_chars.pop_front();
        if (got.character !== want.character)
          report($sformatf("character %0d, want %0d", got.character, want.character));
        if (got.last !== want.last)
          report($sformatf("last %0b on character %0d, want %0b",
                           got.last, want.character, want.last));
      end
    endtask
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  decimal_text_scoreboard sb = new();

  // Idling switches; each phase of the random part sets them.
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  int stall_budget = 0;

  binary_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one number and hold it until the transfer. Entered and left at a
  // falling edge; valid is only lowered when a gap is drawn, so a back-to-back
  // transfer never sees valid dropped and raised in the same step.
  task automatic send_number(input logic [63:0] value, input logic signed_mode);
    in_t item;
    int  gap;
    item.value       = value;
    item.signed_mode = signed_mode;
    gap              = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_number(item);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every queued character has been read.
  task automatic wait_for_text();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // Read side: check each output transfer at the rising edge and draw the
  // stall that precedes the next one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_char(out_data_o);
      stall_budget = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // Spend the drawn stall one cycle at a time; release it otherwise.
  always @(negedge clk_i) begin
    if (stall_budget > 0) begin
      out_stall_i <= 1'b1;
      stall_budget--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    logic [63:0] raw;
    logic [63:0] value;
    logic [63:0] tens;
    logic        mode;
    int unsigned span;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero, the ends of both ranges, the sign-only value, one- and
    // twenty-digit texts and the edges around powers of ten.
    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(SIGN_ONLY, 1'b1);
    send_number(SIGN_ONLY, 1'b0);
    send_number(SIGN_ONLY + 64'd1, 1'b1);
    send_number(SIGN_ONLY + 64'd1, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'd1, 1'b1);
    send_number(64'd9, 1'b0);
    send_number(64'd10, 1'b1);
    send_number(64'd99, 1'b0);
    send_number(64'd100, 1'b1);
    send_number(64'd10_000_000_000_000_000_000, 1'b0);
    send_number(64'd9_999_999_999_999_999_999, 1'b0);
    send_number(~64'd10 + 64'd1, 1'b1);
    send_number(64'd12345, 1'b1);
    send_number(64'h5555_5555_5555_5555, 1'b1);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    wait_for_text();

    // Random: full-width words, short values (often negated in signed mode)
    // and neighbours of powers of ten, in phases with and without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      tx_idle_on = (phase != 1) && (phase != 3);
      rx_idle_on = (phase != 1) && (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        raw  = {$urandom, $urandom};
        mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: value = raw;
          1, 2: begin
            span  = $urandom_range(1, 64);
            value = raw >> (64 - span);
            if (mode && $urandom_range(0, 1) == 1) value = ~value + 64'd1;
          end
          default: begin
            tens = 64'd1;
            repeat ($urandom_range(0, 19)) tens = tens * DEC_BASE;
            value = tens + 64'($urandom_range(0, 2)) - 64'd1;
          end
        endcase
        send_number(value, mode);
      end
      // Let the block run dry after the odd phases.
      if (phase % 2 == 1) wait_for_text();
    end

    wait_for_text();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers into %0d checked characters, signed and unsigned,",
             sb.numbers_seen, sb.chars_checked);
    $display("from zero to twenty digits, with the sign-only value and random stalls.");
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
